[hw/rtl/qtm_pkg.sv]
// Shared widths, constants and control types of the quaternion to transform matrix block.
`default_nettype none

package qtm_pkg;

	localparam int QUAT_W   = 16;
	localparam int SCALE_W  = 16;
	localparam int POS_W    = 32;
	localparam int PROD_W   = 2 * QUAT_W;
	localparam int ENTRY_W  = PROD_W + 2;
	localparam int SCALED_W = ENTRY_W + SCALE_W;
	localparam int RES_W    = 32;
	localparam int FRAC_DROP = 20;

	localparam int IN_DATA_W  = 7 * QUAT_W + 3 * POS_W;
	localparam int OUT_DATA_W = 12 * RES_W;

	// One in Q.28, used on the diagonal.
	localparam logic signed [ENTRY_W-1:0] ONE_Q28 = ENTRY_W'(64'sd1 <<< 28);
	// Half an output LSB in Q.36, for round to nearest with ties up.
	localparam logic signed [SCALED_W-1:0] HALF_LSB = SCALED_W'(64'sd1 <<< (FRAC_DROP - 1));

	typedef struct packed {
		logic en_s3;
		logic en_s4;
	} stage_en_t;

endpackage

`default_nettype wire

[hw/rtl/qtm_scale_round.sv]
// Scales one rotation entry by its row scale and rounds the result to Q16.16.
`default_nettype none

module qtm_scale_round
	import qtm_pkg::*;
(
	input  wire logic                       clk,
	input  wire stage_en_t                  stage_en,
	input  wire logic signed [ENTRY_W-1:0]  entry_s2,
	input  wire logic signed [SCALE_W-1:0]  scale_s2,
	output logic        [RES_W-1:0]         result_s4
);

	logic signed [SCALED_W-1:0] scaled_s3;
	logic signed [SCALED_W-1:0] rounded;

	always_ff @(posedge clk) begin
		if (stage_en.en_s3) begin
			scaled_s3 <= SCALED_W'(entry_s2) * SCALED_W'(scale_s2);
		end
	end

	// Adding half an LSB and then flooring gives nearest with ties toward plus infinity.
	assign rounded = scaled_s3 + HALF_LSB;

	always_ff @(posedge clk) begin
		if (stage_en.en_s4) begin
			result_s4 <= RES_W'($signed(rounded[SCALED_W-1:FRAC_DROP]));
		end
	end

endmodule

`default_nettype wire

[hw/rtl/quaternion_to_transform_matrix_top.sv]
// Top level: quaternion, row scale and translation in, scaled rotation and translation out.
// Throughput: one item per cycle while the output keeps taking them; the four register
// stages (products, entries, scale multiply, rounding) each take a new item whenever the
// stage after them moves or is empty.
// Reset: arst_n clears all stage valid bits asynchronously; the data registers are not reset.
`default_nettype none

module quaternion_to_transform_matrix_top
	import qtm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z
	output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

	logic signed [QUAT_W-1:0]  quat_x, quat_y, quat_z, quat_w;
	logic signed [SCALE_W-1:0] scale_x, scale_y, scale_z;
	logic        [POS_W-1:0]   pos_x, pos_y, pos_z;

	assign quat_x  = s_axis_tdata[15:0];
	assign quat_y  = s_axis_tdata[31:16];
	assign quat_z  = s_axis_tdata[47:32];
	assign quat_w  = s_axis_tdata[63:48];
	assign scale_x = s_axis_tdata[79:64];
	assign scale_y = s_axis_tdata[95:80];
	assign scale_z = s_axis_tdata[111:96];
	assign pos_x   = s_axis_tdata[143:112];
	assign pos_y   = s_axis_tdata[175:144];
	assign pos_z   = s_axis_tdata[207:176];

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2;
	stage_en_t stage_en;

	// Each stage loads when it is empty or its contents move on.
	assign stage_en.en_s4 = !v_s4 || m_axis_tready;
	assign stage_en.en_s3 = !v_s3 || stage_en.en_s4;
	assign en_s2          = !v_s2 || stage_en.en_s3;
	assign en_s1          = !v_s1 || en_s2;
	assign s_axis_tready  = en_s1;
	assign m_axis_tvalid  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1)          v_s1 <= s_axis_tvalid;
			if (en_s2)          v_s2 <= v_s1;
			if (stage_en.en_s3) v_s3 <= v_s2;
			if (stage_en.en_s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: the ten pairwise products, exact in Q.28.
	logic signed [PROD_W-1:0]  xx_s1, yy_s1, zz_s1, ww_s1, xy_s1, xz_s1, xw_s1;
	logic signed [PROD_W-1:0]  yz_s1, yw_s1, zw_s1;
	logic signed [SCALE_W-1:0] sx_s1, sy_s1, sz_s1;
	logic        [POS_W-1:0]   px_s1, py_s1, pz_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			xx_s1 <= PROD_W'(quat_x) * PROD_W'(quat_x);
			yy_s1 <= PROD_W'(quat_y) * PROD_W'(quat_y);
			zz_s1 <= PROD_W'(quat_z) * PROD_W'(quat_z);
			ww_s1 <= PROD_W'(quat_w) * PROD_W'(quat_w);
			xy_s1 <= PROD_W'(quat_x) * PROD_W'(quat_y);
			xz_s1 <= PROD_W'(quat_x) * PROD_W'(quat_z);
			xw_s1 <= PROD_W'(quat_x) * PROD_W'(quat_w);
			yz_s1 <= PROD_W'(quat_y) * PROD_W'(quat_z);
			yw_s1 <= PROD_W'(quat_y) * PROD_W'(quat_w);
			zw_s1 <= PROD_W'(quat_z) * PROD_W'(quat_w);
			sx_s1 <= scale_x;
			sy_s1 <= scale_y;
			sz_s1 <= scale_z;
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			pz_s1 <= pos_z;
		end
	end

	// Stage 2: the nine rotation entries, twice a sum or difference (less one on the diagonal), in Q.28.
	logic signed [ENTRY_W-2:0] sum00, sum01, sum02, sum10, sum11, sum12, sum20, sum21, sum22;
	logic signed [ENTRY_W-1:0] entry_s2 [9];
	logic signed [SCALE_W-1:0] row_scale_s2 [3];
	logic        [POS_W-1:0]   px_s2, py_s2, pz_s2;

	assign sum00 = (ENTRY_W-1)'(xx_s1) + (ENTRY_W-1)'(ww_s1);
	assign sum01 = (ENTRY_W-1)'(xy_s1) - (ENTRY_W-1)'(zw_s1);
	assign sum02 = (ENTRY_W-1)'(xz_s1) + (ENTRY_W-1)'(yw_s1);
	assign sum10 = (ENTRY_W-1)'(xy_s1) + (ENTRY_W-1)'(zw_s1);
	assign sum11 = (ENTRY_W-1)'(yy_s1) + (ENTRY_W-1)'(ww_s1);
	assign sum12 = (ENTRY_W-1)'(yz_s1) - (ENTRY_W-1)'(xw_s1);
	assign sum20 = (ENTRY_W-1)'(xz_s1) - (ENTRY_W-1)'(yw_s1);
	assign sum21 = (ENTRY_W-1)'(yz_s1) + (ENTRY_W-1)'(xw_s1);
	assign sum22 = (ENTRY_W-1)'(zz_s1) + (ENTRY_W-1)'(ww_s1);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			entry_s2[0] <= $signed({sum00, 1'b0}) - ONE_Q28;
			entry_s2[1] <= $signed({sum01, 1'b0});
			entry_s2[2] <= $signed({sum02, 1'b0});
			entry_s2[3] <= $signed({sum10, 1'b0});
			entry_s2[4] <= $signed({sum11, 1'b0}) - ONE_Q28;
			entry_s2[5] <= $signed({sum12, 1'b0});
			entry_s2[6] <= $signed({sum20, 1'b0});
			entry_s2[7] <= $signed({sum21, 1'b0});
			entry_s2[8] <= $signed({sum22, 1'b0}) - ONE_Q28;
			row_scale_s2[0] <= sx_s1;
			row_scale_s2[1] <= sy_s1;
			row_scale_s2[2] <= sz_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pz_s2 <= pz_s1;
		end
	end

	// Stages 3 and 4: scale multiply and rounding, one unit per entry.
	logic [RES_W-1:0] m_s4 [9];

	for (genvar i = 0; i < 9; i++) begin : g_entry
		qtm_scale_round u_scale_round (
			.clk       (clk),
			.stage_en  (stage_en),
			.entry_s2  (entry_s2[i]),
			.scale_s2  (row_scale_s2[i / 3]),
			.result_s4 (m_s4[i])
		);
	end

	// The translation rides alongside so that it leaves with its own matrix.
	logic [POS_W-1:0] px_s3, py_s3, pz_s3;
	logic [POS_W-1:0] px_s4, py_s4, pz_s4;

	always_ff @(posedge clk) begin
		if (stage_en.en_s3) begin
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pz_s3 <= pz_s2;
		end
		if (stage_en.en_s4) begin
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			pz_s4 <= pz_s3;
		end
	end

	assign m_axis_tdata = {pz_s4, py_s4, px_s4,
		m_s4[8], m_s4[7], m_s4[6], m_s4[5], m_s4[4], m_s4[3], m_s4[2], m_s4[1], m_s4[0]};

	// An empty output register means nothing downstream can hold the input back.
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input not ready although the output register is empty");

	// An accepted item occupies the first stage in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> v_s1)
		else $error("accepted item did not reach the first stage");

	// With every stage full and the output stalled, no item may enter.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && !m_axis_tready |-> !s_axis_tready)
		else $error("input ready while the pipeline is full and stalled");

	// An item in the multiply stage moves to the output when the output can take it.
	a_s3_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && stage_en.en_s4 |=> m_axis_tvalid)
		else $error("item in the multiply stage was lost on its way out");

endmodule

`default_nettype wire

[sim/quaternion_to_transform_matrix_top_tb.sv]
// Self-checking testbench: random and corner-case poses against a fixed-point transform predictor.
`timescale 1ns / 1ps

module quaternion_to_transform_matrix_top_tb;
	import qtm_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_POSES = 750;

	// Fields in the order of the port, first field in the lowest bits.
	typedef struct packed {
		logic signed [POS_W-1:0]   pos_z;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [SCALE_W-1:0] scale_z;
		logic signed [SCALE_W-1:0] scale_y;
		logic signed [SCALE_W-1:0] scale_x;
		logic signed [QUAT_W-1:0]  quat_w;
		logic signed [QUAT_W-1:0]  quat_z;
		logic signed [QUAT_W-1:0]  quat_y;
		logic signed [QUAT_W-1:0]  quat_x;
	} pose_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	wire                   s_axis_tready;
	// quat_x, quat_y, quat_z, quat_w, scale_x, scale_y, scale_z, pos_x, pos_y, pos_z
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	wire                   m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// m00, m01, m02, m10, m11, m12, m20, m21, m22, t_x, t_y, t_z
	wire [OUT_DATA_W-1:0]  m_axis_tdata;

	pose_t                 pending_poses[$];
	logic [OUT_DATA_W-1:0] expected_mats[$];
	string                 mat_names[12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
		"m20", "m21", "m22", "t_x", "t_y", "t_z"};
	int                    fail_count = 0;
	int                    mats_seen = 0;
	int                    idle_cycles = 0;
	int unsigned           src_wait = 0;
	int unsigned           sink_wait = 0;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;
	bit                    src_burst = 1'b0;
	bit                    sink_burst = 1'b0;

	quaternion_to_transform_matrix_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	// Q.28 entry times Q8.8 scale, rounded to nearest Q16.16 with ties going up.
	function automatic logic [RES_W-1:0] round_q16(longint entry, longint scale);
		longint v;
		v = entry * scale + (64'sd1 <<< 19);
		return RES_W'(v >>> 20);
	endfunction

	function automatic logic [OUT_DATA_W-1:0] transform_of(pose_t p);
		longint x, y, z, w, sx, sy, sz;
		longint xx, yy, zz, ww, xy, xz, xw, yz, yw, zw;
		longint one;
		x = longint'(p.quat_x);
		y = longint'(p.quat_y);
		z = longint'(p.quat_z);
		w = longint'(p.quat_w);
		sx = longint'(p.scale_x);
		sy = longint'(p.scale_y);
		sz = longint'(p.scale_z);
		one = 64'sd1 <<< 28;
		xx = x * x; yy = y * y; zz = z * z; ww = w * w;
		xy = x * y; xz = x * z; xw = x * w;
		yz = y * z; yw = y * w; zw = z * w;
		return {p.pos_z, p.pos_y, p.pos_x,
			round_q16(2 * (zz + ww) - one, sz),
			round_q16(2 * (yz + xw), sz),
			round_q16(2 * (xz - yw), sz),
			round_q16(2 * (yz - xw), sy),
			round_q16(2 * (yy + ww) - one, sy),
			round_q16(2 * (xy + zw), sy),
			round_q16(2 * (xz + yw), sx),
			round_q16(2 * (xy - zw), sx),
			round_q16(2 * (xx + ww) - one, sx)};
	endfunction

	// Extremes and zero turn up often so that the corners stay busy.
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic add_pose(input int x, y, z, w, sx, sy, sz, px, py, pz);
		pose_t p;
		p.quat_x = 16'(x); p.quat_y = 16'(y); p.quat_z = 16'(z); p.quat_w = 16'(w);
		p.scale_x = 16'(sx); p.scale_y = 16'(sy); p.scale_z = 16'(sz);
		p.pos_x = px; p.pos_y = py; p.pos_z = pz;
		pending_poses.push_back(p);
	endtask

	// Sender: each item is followed by a random gap, except in bursts.
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			src_wait <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				gap = src_burst ? 0 : $urandom_range(0, 14);
				if (gap == 0 && pending_poses.size() != 0) begin
					s_axis_tdata <= pending_poses.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
					src_wait <= (gap != 0) ? gap - 1 : 0;
				end
			end else if (!s_axis_tvalid) begin
				if (src_wait != 0) begin
					src_wait <= src_wait - 1;
				end else if (pending_poses.size() != 0) begin
					s_axis_tdata <= pending_poses.pop_front();
					s_axis_tvalid <= 1'b1;
				end
			end
			if ($urandom_range(0, 49) == 0)
				src_burst <= !src_burst;
		end
	end

	// Receiver: random stalls after each item, and one long hold-off that fills the pipeline.
	always @(posedge clk or negedge arst_n) begin
		int unsigned gap;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_wait <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (!hold_done && mats_seen >= 300) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				sink_wait <= 0;
				m_axis_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end else if (m_axis_tready) begin
				if (m_axis_tvalid) begin
					gap = sink_burst ? 0 : $urandom_range(0, 14);
					if (gap != 0) begin
						m_axis_tready <= 1'b0;
						sink_wait <= gap - 1;
					end
				end
			end else if (sink_wait != 0) begin
				sink_wait <= sink_wait - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if ($urandom_range(0, 49) == 0)
				sink_burst <= !sink_burst;
		end
	end

	// Monitor: predicts on input acceptance, then checks any result item at the same edge.
	always @(posedge clk) begin
		logic [OUT_DATA_W-1:0] want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_mats.push_back(transform_of(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				mats_seen <= mats_seen + 1;
				if (expected_mats.size() == 0) begin
					$error("result item with no expectation waiting");
					fail_count++;
				end else begin
					want = expected_mats.pop_front();
					for (int i = 0; i < 12; i++) begin
						if (m_axis_tdata[i*RES_W +: RES_W] !== want[i*RES_W +: RES_W]) begin
							$error("%s: expected %0d, actual %0d", mat_names[i],
								$signed(want[i*RES_W +: RES_W]),
								$signed(m_axis_tdata[i*RES_W +: RES_W]));
							fail_count++;
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("quaternion_to_transform_matrix_top_tb: errors");
			$finish;
		end
	end

	initial begin
		pose_t p;
		// Directed corners.
		add_pose(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_pose(0, 0, 0, 16384, 256, 256, 256, 32'sh00010000, -32'sh00020000, 32'sh00030000);
		add_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		add_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
			32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_pose(-32768, 32767, -32768, 32767, 32767, -32768, 256,
			32'sh80000000, 32'sh7fffffff, 32'shffffffff);
		add_pose(32767, -32768, 32767, -32768, -32768, 32767, -256, 0, -1, 1);
		add_pose(16384, 0, 0, 0, 256, 256, 256, 1, 2, 3);
		add_pose(0, 16384, 0, 0, 256, 256, 256, -1, -2, -3);
		add_pose(0, 0, 16384, 0, 256, 256, 256, 32'sh12345678, 32'sh0, 32'sh7fffffff);
		add_pose(0, 0, 0, -16384, -256, -256, -256, 32'sh80000001, 0, 0);
		add_pose(-16384, 0, 0, 0, 1, -1, 0, 0, 0, 0);
		// Exact ties of the rounding, positive and negative.
		add_pose(128, 128, 0, 0, 16, 16, 16, 0, 0, 0);
		add_pose(128, 128, 0, 0, -16, -16, -16, 0, 0, 0);
		add_pose(-128, 128, 128, 0, 16, -16, 16, 0, 0, 0);
		add_pose(0, 0, 0, 0, 32767, -32768, 1, 0, 0, 0);
		add_pose(11585, 0, 0, 11585, 256, 512, -128, 32'sh00008000, -32'sh00008000, 0);
		add_pose(8192, 8192, 8192, 8192, 256, 256, 256, 32'sh0000ffff, 32'shffff0000, 0);
		add_pose(1, -1, 1, -1, 32767, -32768, 32767, -1, -1, -1);
		for (int n = 0; n < RANDOM_POSES; n++) begin
			p.quat_x = pick16();
			p.quat_y = pick16();
			p.quat_z = pick16();
			p.quat_w = pick16();
			p.scale_x = pick16();
			p.scale_y = pick16();
			p.scale_z = pick16();
			p.pos_x = $urandom;
			p.pos_y = $urandom;
			p.pos_z = $urandom;
			pending_poses.push_back(p);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_poses.size() != 0 || s_axis_tvalid || expected_mats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0 && expected_mats.size() == 0) begin
			$display("quaternion_to_transform_matrix_top_tb: clean");
		end else begin
			$display("quaternion_to_transform_matrix_top_tb: errors");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/qtm_pkg.sv
hw/rtl/qtm_scale_round.sv
hw/rtl/quaternion_to_transform_matrix_top.sv
sim/quaternion_to_transform_matrix_top_tb.sv
